// ----- rtl/hlm_pkg.sv -----
// ----------------------------------------------------------------------------
// hlm_pkg
// Shared widths, Gauss-point constants and corner sign tables for the
// hexahedral lumped mass unit.
// ----------------------------------------------------------------------------
package hlm_pkg;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 35;
  localparam int PROD_W = 2 * MUL_W;

  // Register index of the density register
  localparam logic REG_DENSITY = 1'b0;

  // Gauss factors 1 + g and 1 - g in Q28, g = 1/sqrt(3)
  localparam logic [63:0] GAUSS_Q28 = 64'd154981283;
  localparam logic [63:0] ONE_Q28   = 64'd268435456;
  localparam logic [63:0] FAC_P     = ONE_Q28 + GAUSS_Q28;
  localparam logic [63:0] FAC_M     = ONE_Q28 - GAUSS_Q28;

  typedef logic [29:0] coef_t;

  // Rounded product of two Gauss factors, Q28
  function automatic coef_t pair_coef(input logic f0_plus, input logic f1_plus);
    logic [63:0] f0;
    logic [63:0] f1;
    logic [63:0] t;
    f0 = f0_plus ? FAC_P : FAC_M;
    f1 = f1_plus ? FAC_P : FAC_M;
    t  = (f0 * f1 + 64'd134217728) >> 28;
    return t[29:0];
  endfunction

  // Shape function value for a match pattern (bit d set: factor 1 + g)
  function automatic coef_t shape_val(input logic [2:0] m);
    logic [63:0] t;
    logic [63:0] f2;
    logic [63:0] n;
    t  = {34'd0, pair_coef(m[0], m[1])};
    f2 = m[2] ? FAC_P : FAC_M;
    n  = (t * f2 + 64'd1073741824) >> 31;
    return n[29:0];
  endfunction

  localparam coef_t COEF_PP = pair_coef(1'b1, 1'b1);
  localparam coef_t COEF_PM = pair_coef(1'b1, 1'b0);
  localparam coef_t COEF_MM = pair_coef(1'b0, 1'b0);

  localparam coef_t N_TAB [8] = '{
    shape_val(3'd0), shape_val(3'd1), shape_val(3'd2), shape_val(3'd3),
    shape_val(3'd4), shape_val(3'd5), shape_val(3'd6), shape_val(3'd7)
  };

  // Corner sign bits {z, y, x}, 1 for the positive side
  function automatic logic [2:0] corner_pos(input logic [2:0] a);
    return {a[2], a[1], a[0] ^ a[1]};
  endfunction

endpackage

// ----- rtl/hlm_mul.sv -----
// ----------------------------------------------------------------------------
// hlm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hlm_mul (
  input  logic                               clk,
  input  logic signed [hlm_pkg::MUL_W-1:0]   a,
  input  logic signed [hlm_pkg::MUL_W-1:0]   b,
  output logic signed [hlm_pkg::PROD_W-1:0]  p
);
  import hlm_pkg::*;

  // Register the product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/hex8_lumped_mass_unit.sv -----
// ----------------------------------------------------------------------------
// hex8_lumped_mass_unit
// Row-sum lumped mass of a trilinear hexahedral element, 2x2x2 Gauss rule,
// computed on one shared 35x35 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Items one to seven are stored as they are accepted. After the eighth item,
// 8 Gauss points each compute the Jacobian (nine entries over eight corners),
// determinant (six triple terms), absolute value and node shares, with the
// products on the shared multiplier, then 8 result items, one per cycle if not
// stalled. Input is stalled from the eighth item until the last result leaves.
// Reset (rst, synchronous) restarts corner loading and sets density to 1.0.
module hex8_lumped_mass_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [20:0]         node_number,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [20:0]         out_node_number,
  output logic signed [63:0]  mass_share,
  output logic                last_node
);
  import hlm_pkg::*;

  localparam int SHIFT = 3 * COORD_FRAC_BITS + 12;
  localparam logic [159:0] BIAS = 160'd1 << (SHIFT - 1);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_JAC  = 3'd1;
  localparam logic [2:0] ST_DET  = 3'd2;
  localparam logic [2:0] ST_ABS  = 3'd3;
  localparam logic [2:0] ST_MASS = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state;
  logic [2:0]  load_cnt;
  logic [2:0]  g;
  logic [3:0]  e;
  logic [2:0]  a_idx;
  logic [2:0]  tri_idx;
  logic [2:0]  step;
  logic        ph;
  logic [2:0]  nidx;
  logic [31:0] density;

  logic [20:0]        nn_store [8];
  logic signed [31:0] xs [8];
  logic signed [31:0] ys [8];
  logic signed [31:0] zs [8];

  logic signed [33:0] jac [9];
  logic signed [63:0] jacc;
  logic signed [63:0] pq;
  logic signed [97:0] det;
  logic [95:0]        mag;
  logic               neg;
  logic [61:0]        rn;
  logic [159:0]       big;
  logic signed [63:0] macc [8];

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [1:0]  e_d;
  logic [1:0]  e_c;
  logic [2:0]  mv_jac;
  logic [2:0]  mv_node;
  logic [2:0]  cp_a;
  logic [2:0]  cm;
  logic [1:0]  cnt;
  coef_t       coef;
  logic signed [31:0] coord;
  logic               term_plus;
  logic signed [63:0] jsum_next;
  logic [63:0]        jmag;
  logic [63:0]        jrnd;
  logic signed [33:0] jval;
  logic signed [33:0] tp;
  logic signed [33:0] tq;
  logic signed [33:0] tw;
  logic               tneg;
  logic signed [MUL_W-1:0] wn;
  logic [97:0]  det_abs;
  logic [7:0]   big_sh;
  logic         over;
  logic [62:0]  vmag;
  logic signed [63:0] contrib;
  logic signed [63:0] acc_old;
  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_new;
  logic         in_acc;
  logic         cfg_wr;

  hlm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DENSITY) ? density : 32'd0;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_DENSITY);

  // Handshakes and result fields
  assign in_stall        = (state != ST_LOAD);
  assign in_acc          = in_valid & ~in_stall;
  assign out_valid       = (state == ST_OUT);
  assign out_node_number = nn_store[nidx];
  assign mass_share      = macc[nidx];
  assign last_node       = (nidx == 3'd7);

  // Split the Jacobian entry index into row and column
  always_comb begin
    unique case (e)
      4'd0: begin e_d = 2'd0; e_c = 2'd0; end
      4'd1: begin e_d = 2'd0; e_c = 2'd1; end
      4'd2: begin e_d = 2'd0; e_c = 2'd2; end
      4'd3: begin e_d = 2'd1; e_c = 2'd0; end
      4'd4: begin e_d = 2'd1; e_c = 2'd1; end
      4'd5: begin e_d = 2'd1; e_c = 2'd2; end
      4'd6: begin e_d = 2'd2; e_c = 2'd0; end
      4'd7: begin e_d = 2'd2; e_c = 2'd1; end
      default: begin e_d = 2'd2; e_c = 2'd2; end
    endcase
  end

  // Derivative coefficient: factors of the two other directions
  always_comb begin
    cp_a      = corner_pos(a_idx);
    mv_jac    = ~(cp_a ^ corner_pos(g));
    mv_node   = ~(corner_pos(nidx) ^ corner_pos(g));
    cm        = mv_jac & ~(3'b001 << e_d);
    cnt       = {1'b0, cm[0]} + {1'b0, cm[1]} + {1'b0, cm[2]};
    term_plus = cp_a[e_d];
    unique case (cnt)
      2'd2:    coef = COEF_PP;
      2'd1:    coef = COEF_PM;
      default: coef = COEF_MM;
    endcase
    unique case (e_c)
      2'd0:    coord = xs[a_idx];
      2'd1:    coord = ys[a_idx];
      default: coord = zs[a_idx];
    endcase
  end

  // Determinant triple terms
  always_comb begin
    unique case (tri_idx)
      3'd1:    begin tp = jac[1]; tq = jac[5]; tw = jac[6]; tneg = 1'b0; end
      3'd2:    begin tp = jac[2]; tq = jac[3]; tw = jac[7]; tneg = 1'b0; end
      3'd3:    begin tp = jac[2]; tq = jac[4]; tw = jac[6]; tneg = 1'b1; end
      3'd4:    begin tp = jac[5]; tq = jac[7]; tw = jac[0]; tneg = 1'b1; end
      3'd5:    begin tp = jac[8]; tq = jac[1]; tw = jac[3]; tneg = 1'b1; end
      default: begin tp = jac[0]; tq = jac[4]; tw = jac[8]; tneg = 1'b0; end
    endcase
    wn = tneg ? -{tw[33], tw} : {tw[33], tw};
  end

  // Select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    big_sh = 8'd0;
    unique case (state)
      ST_JAC: begin
        mul_a = {5'd0, coef};
        mul_b = {{3{coord[31]}}, coord};
      end
      ST_DET: begin
        unique case (step)
          3'd0: begin
            mul_a = {tp[33], tp};
            mul_b = {tq[33], tq};
          end
          3'd1: begin
            mul_a = {3'd0, pq[31:0]};
            mul_b = wn;
          end
          default: begin
            mul_a = {{3{pq[63]}}, pq[63:32]};
            mul_b = wn;
          end
        endcase
      end
      ST_MASS: begin
        unique case (step)
          3'd0: begin
            mul_a = {3'd0, density};
            mul_b = {5'd0, N_TAB[mv_node]};
          end
          3'd1: begin
            mul_a = {3'd0, mag[31:0]};  mul_b = {3'd0, rn[31:0]};  big_sh = 8'd0;
          end
          3'd2: begin
            mul_a = {3'd0, mag[63:32]}; mul_b = {3'd0, rn[31:0]};  big_sh = 8'd32;
          end
          3'd3: begin
            mul_a = {3'd0, mag[31:0]};  mul_b = {5'd0, rn[61:32]}; big_sh = 8'd32;
          end
          3'd4: begin
            mul_a = {3'd0, mag[95:64]}; mul_b = {3'd0, rn[31:0]};  big_sh = 8'd64;
          end
          3'd5: begin
            mul_a = {3'd0, mag[63:32]}; mul_b = {5'd0, rn[61:32]}; big_sh = 8'd64;
          end
          3'd6: begin
            mul_a = {3'd0, mag[95:64]}; mul_b = {5'd0, rn[61:32]}; big_sh = 8'd96;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Jacobian sum and its rounding, half away from zero
  always_comb begin
    jsum_next = term_plus ? (jacc + prod[63:0]) : (jacc - prod[63:0]);
    jmag      = jsum_next[63] ? (64'd0 - jsum_next) : jsum_next;
    jrnd      = (jmag + 64'd1073741824) >> 31;
    jval      = jsum_next[63] ? (34'd0 - jrnd[33:0]) : jrnd[33:0];
    det_abs   = det[97] ? (98'd0 - det) : det;
  end

  // Node share: round, saturate, then saturating accumulate
  always_comb begin
    over    = |big[159:SHIFT+63];
    vmag    = big[SHIFT+62:SHIFT];
    if (over) begin
      contrib = neg ? S64_MIN : S64_MAX;
    end else begin
      contrib = neg ? (64'd0 - {1'b0, vmag}) : {1'b0, vmag};
    end
    acc_old = (g == 3'd0) ? 64'sd0 : macc[nidx];
    acc_sum = acc_old + contrib;
    if (acc_old[63] == contrib[63] && acc_sum[63] != acc_old[63]) begin
      acc_new = acc_old[63] ? S64_MIN : S64_MAX;
    end else begin
      acc_new = acc_sum;
    end
  end

  // Density register
  always_ff @(posedge clk) begin
    if (rst) begin
      density <= 32'd65536;
    end else if (cfg_wr) begin
      density <= pwdata;
    end
  end

  // Store corners
  always_ff @(posedge clk) begin
    if (in_acc) begin
      nn_store[load_cnt] <= node_number;
      xs[load_cnt]       <= coord_x;
      ys[load_cnt]       <= coord_y;
      zs[load_cnt]       <= coord_z;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      load_cnt <= 3'd0;
      g        <= 3'd0;
      e        <= 4'd0;
      a_idx    <= 3'd0;
      tri_idx  <= 3'd0;
      step     <= 3'd0;
      ph       <= 1'b0;
      nidx     <= 3'd0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_cnt == 3'd7) begin
              load_cnt <= 3'd0;
              g        <= 3'd0;
              e        <= 4'd0;
              a_idx    <= 3'd0;
              ph       <= 1'b0;
              jacc     <= '0;
              state    <= ST_JAC;
            end else begin
              load_cnt <= load_cnt + 3'd1;
            end
          end
        end
        ST_JAC: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (a_idx == 3'd7) begin
              jac[e] <= jval;
              jacc   <= '0;
              a_idx  <= 3'd0;
              if (e == 4'd8) begin
                tri_idx <= 3'd0;
                step    <= 3'd0;
                det     <= '0;
                state   <= ST_DET;
              end else begin
                e <= e + 4'd1;
              end
            end else begin
              jacc  <= jsum_next;
              a_idx <= a_idx + 3'd1;
            end
          end
        end
        ST_DET: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            unique case (step)
              3'd0: begin
                pq   <= prod[63:0];
                step <= 3'd1;
              end
              3'd1: begin
                det  <= det + {{28{prod[PROD_W-1]}}, prod};
                step <= 3'd2;
              end
              default: begin
                det  <= det + ({{28{prod[PROD_W-1]}}, prod} << 32);
                step <= 3'd0;
                if (tri_idx == 3'd5) begin
                  state <= ST_ABS;
                end else begin
                  tri_idx <= tri_idx + 3'd1;
                end
              end
            endcase
          end
        end
        ST_ABS: begin
          mag   <= det_abs[95:0];
          neg   <= det[97];
          nidx  <= 3'd0;
          step  <= 3'd0;
          ph    <= 1'b0;
          state <= ST_MASS;
        end
        ST_MASS: begin
          if (step == 3'd7) begin
            macc[nidx] <= acc_new;
            step       <= 3'd0;
            if (nidx == 3'd7) begin
              nidx <= 3'd0;
              if (g == 3'd7) begin
                state <= ST_OUT;
              end else begin
                g     <= g + 3'd1;
                e     <= 4'd0;
                a_idx <= 3'd0;
                state <= ST_JAC;
              end
            end else begin
              nidx <= nidx + 3'd1;
            end
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph   <= 1'b0;
            step <= step + 3'd1;
            if (step == 3'd0) begin
              rn  <= prod[61:0];
              big <= BIAS;
            end else begin
              big <= big + ({96'd0, prod[63:0]} << big_sh);
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (nidx == 3'd7) begin
              nidx  <= 3'd0;
              state <= ST_LOAD;
            end else begin
              nidx <= nidx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
